// ----- sv/blr_pkg.sv -----
`default_nettype none

package blr_pkg;

  // Item kind carried on the input channel and through the command queue
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  // Back-end status seen by the queue and the top level
  typedef struct packed {
    logic pop;
    logic emit;
    logic active;
  } back_stat_t;

  // Width of one queued command for a given coordinate width
  function automatic int entry_bits(input int coord_bits);
    return 6 * coord_bits + 10;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bresenham_line_raster.sv -----
`default_nettype none

// Bresenham line rasterizer for all octants. A load item (kind 0) takes two
// endpoints and gives no result; each step item (kind 1) gives the next pixel
// from the first endpoint through the second, both included, with out_last set
// on the second. A step item while no line is active is dropped, and a load in
// the middle of a line abandons it. The block takes one item per clock while
// the queue has room: the front end works out spans, direction and error-term
// setup combinationally and writes a 4-entry command queue; the back end
// retires one command per clock unless a live step waits on a stalled output,
// with a single add on the error term, and holds the pixel in an output
// register. in_stall rises only when the queue is full.
module bresenham_line_raster #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic                       out_last
);

  localparam int EntryW = blr_pkg::entry_bits(COORD_BITS);

  logic                q_full;
  logic                q_push;
  logic [EntryW-1:0]   q_wdata;
  logic                q_valid;
  logic [EntryW-1:0]   q_rdata;
  blr_pkg::back_stat_t stat;

  // Classify and set up each accepted item
  blr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // Decouple setup from the pixel walk
  blr_queue #(.WIDTH(EntryW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .pop        (stat.pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_rdata)
  );

  // Walk the line and register each pixel
  blr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_last    (out_last)
  );

  // A new pixel never overwrites a result that is still stalled
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> !(out_valid && out_stall))
    else $error("pixel emitted over a stalled result");

  // The back end retires only commands that are present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> q_valid)
    else $error("queue popped while empty");

  // An emitted pixel shows up on the output next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |=> out_valid)
    else $error("emitted pixel not presented");

  // Pixels come only from an active line
  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> stat.active)
    else $error("pixel emitted with no active line");

endmodule

`default_nettype wire

// ----- sv/blr_front.sv -----
`default_nettype none

module blr_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic                                        in_kind,
  input  wire logic [COORD_BITS-1:0]                       in_start_x,
  input  wire logic [COORD_BITS-1:0]                       in_start_y,
  input  wire logic [COORD_BITS-1:0]                       in_end_x,
  input  wire logic [COORD_BITS-1:0]                       in_end_y,
  input  wire logic                                        q_full,
  output logic                                             q_push,
  output logic [blr_pkg::entry_bits(COORD_BITS)-1:0]       q_data
);

  typedef struct packed {
    blr_pkg::kind_t                kind;
    logic [COORD_BITS-1:0]         x1;
    logic [COORD_BITS-1:0]         y1;
    logic                          x_major;
    logic                          step_x_neg;
    logic                          step_y_neg;
    logic signed [COORD_BITS+2:0]  err_init;
    logic signed [COORD_BITS+1:0]  diag_incr;
    logic [COORD_BITS:0]           straight_incr;
    logic [COORD_BITS-1:0]         steps;
  } cmd_t;

  logic [COORD_BITS-1:0]       dx;
  logic [COORD_BITS-1:0]       dy;
  logic [COORD_BITS-1:0]       major;
  logic [COORD_BITS-1:0]       minor;
  logic signed [COORD_BITS:0]  span_diff;
  cmd_t                        cmd;

  // Take an item whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the line: direction per axis, spans and major axis
  always_comb begin
    cmd            = '0;
    cmd.kind       = blr_pkg::kind_t'(in_kind);
    cmd.x1         = in_start_x;
    cmd.y1         = in_start_y;
    cmd.step_x_neg = in_end_x < in_start_x;
    cmd.step_y_neg = in_end_y < in_start_y;
    dx             = cmd.step_x_neg ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    dy             = cmd.step_y_neg ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    cmd.x_major    = dx > dy;
    major          = cmd.x_major ? dx : dy;
    minor          = cmd.x_major ? dy : dx;
    // Prepare the error term and its two increments
    span_diff         = $signed({1'b0, minor}) - $signed({1'b0, major});
    cmd.err_init      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    cmd.diag_incr     = {span_diff, 1'b0};
    cmd.straight_incr = {minor, 1'b0};
    cmd.steps         = major;
  end

  assign q_data = cmd;

endmodule

`default_nettype wire

// ----- sv/blr_queue.sv -----
`default_nettype none

module blr_queue #(
  parameter int WIDTH = 82
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    rd_ptr_nxt;
  logic [AW:0]      cnt_r;
  logic [AW:0]      cnt_nxt;
  logic             do_pop;

  assign full       = cnt_r == (AW+1)'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/blr_back.sv -----
`default_nettype none

module blr_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_valid,
  input  wire logic [blr_pkg::entry_bits(COORD_BITS)-1:0] q_data,
  output blr_pkg::back_stat_t                        stat,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [COORD_BITS-1:0]                      out_pixel_x,
  output logic [COORD_BITS-1:0]                      out_pixel_y,
  output logic                                       out_last
);

  typedef struct packed {
    blr_pkg::kind_t                kind;
    logic [COORD_BITS-1:0]         x1;
    logic [COORD_BITS-1:0]         y1;
    logic                          x_major;
    logic                          step_x_neg;
    logic                          step_y_neg;
    logic signed [COORD_BITS+2:0]  err_init;
    logic signed [COORD_BITS+1:0]  diag_incr;
    logic [COORD_BITS:0]           straight_incr;
    logic [COORD_BITS-1:0]         steps;
  } cmd_t;

  cmd_t                          cmd;

  logic                          active_r, active_nxt;
  logic                          first_r, first_nxt;
  logic [COORD_BITS-1:0]         cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]         cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS+2:0]  err_r, err_nxt;
  logic signed [COORD_BITS+1:0]  diag_r, diag_nxt;
  logic [COORD_BITS:0]           straight_r, straight_nxt;
  logic [COORD_BITS-1:0]         steps_r, steps_nxt;
  logic                          xmaj_r, xmaj_nxt;
  logic                          sxn_r, sxn_nxt;
  logic                          syn_r, syn_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]         out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0]         out_y_r, out_y_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_free;
  logic                          is_load;
  logic                          pop;
  logic                          emit;
  logic                          diag_step;
  logic [COORD_BITS-1:0]         step_x;
  logic [COORD_BITS-1:0]         step_y;
  logic signed [COORD_BITS+2:0]  err_adv;

  assign cmd      = cmd_t'(q_data);
  assign out_free = !out_valid_r || !out_stall;
  assign is_load  = cmd.kind == blr_pkg::KIND_LOAD;
  // Loads and dead steps retire at once; live steps wait for the output slot
  assign pop      = q_valid && (is_load || !active_r || out_free);
  assign emit     = q_valid && !is_load && active_r && out_free;

  // One walk step: straight or diagonal by the sign of the error term
  always_comb begin
    diag_step = !err_r[COORD_BITS+2];
    step_x    = sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    step_y    = syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    if (diag_step) begin
      err_adv = err_r + (COORD_BITS+3)'(diag_r);
    end else begin
      err_adv = err_r + $signed({2'b00, straight_r});
    end
  end

  // Load a line or emit the next pixel
  always_comb begin
    active_nxt    = active_r;
    first_nxt     = first_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    diag_nxt      = diag_r;
    straight_nxt  = straight_r;
    steps_nxt     = steps_r;
    xmaj_nxt      = xmaj_r;
    sxn_nxt       = sxn_r;
    syn_nxt       = syn_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    if (pop && is_load) begin
      active_nxt   = 1'b1;
      first_nxt    = 1'b1;
      cur_x_nxt    = cmd.x1;
      cur_y_nxt    = cmd.y1;
      err_nxt      = cmd.err_init;
      diag_nxt     = cmd.diag_incr;
      straight_nxt = cmd.straight_incr;
      steps_nxt    = cmd.steps;
      xmaj_nxt     = cmd.x_major;
      sxn_nxt      = cmd.step_x_neg;
      syn_nxt      = cmd.step_y_neg;
    end else if (emit) begin
      if (first_r) begin
        first_nxt = 1'b0;
      end else begin
        if (xmaj_r || diag_step) begin
          cur_x_nxt = step_x;
        end
        if (!xmaj_r || diag_step) begin
          cur_y_nxt = step_y;
        end
        err_nxt = err_adv;
        if (steps_r != '0) begin
          steps_nxt = steps_r - 1'b1;
        end
      end
      active_nxt    = steps_nxt != '0;
      out_valid_nxt = 1'b1;
      out_x_nxt     = cur_x_nxt;
      out_y_nxt     = cur_y_nxt;
      out_last_nxt  = steps_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    err_r      <= err_nxt;
    diag_r     <= diag_nxt;
    straight_r <= straight_nxt;
    steps_r    <= steps_nxt;
    xmaj_r     <= xmaj_nxt;
    sxn_r      <= sxn_nxt;
    syn_r      <= syn_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.pop    = pop;
  assign stat.emit   = emit;
  assign stat.active = active_r;

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire
